[hw/rtl/nscp_pkg.sv]
// Shared types and constants for the nested-scope cycle profiler.
// No dependencies; used by nscp_div and nested_scope_cycle_profiler.
`default_nettype none
package nscp_pkg;

   localparam int TS_W    = 32;
   localparam int SUM_W   = 40;
   localparam int TRACK_W = 44;
   localparam int DVD_W   = 56;
   localparam int DVS_W   = 40;
   localparam int DEN_W   = 18;
   localparam int VALUE_W = 26;
   localparam int SLOT_W  = 5;
   localparam int STEP_W  = 6;

   localparam int MILLE = 1000;
   localparam int DECI  = 10;

   localparam logic [1:0] OP_FRAME_BEGIN = 2'd0;
   localparam logic [1:0] OP_ENTER       = 2'd1;
   localparam logic [1:0] OP_LEAVE       = 2'd2;
   localparam logic [1:0] OP_FRAME_END   = 2'd3;

   localparam logic [0:0] CSR_ENABLED = 1'd0;
   localparam logic [0:0] CSR_WINDOW  = 1'd1;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

[hw/rtl/nested_scope_cycle_profiler.sv]
// Nested-scope cycle profiler: scope stack, frame and window sums, report sequencer.
// Depends on nscp_pkg and nscp_div.
//
// Usage: events (frame begin, scope enter, scope leave, frame end) arrive on the
// req_ channel with a 32-bit timestamp; a transaction is taken when req_valid is
// high and req_stall low. Each event is handled in the cycle it is taken.
// A frame end that completes a window starts a report of BUCKETS+2 transactions
// on the rsp_ channel (bucket shares, tracked share, average frame cost, the
// last one flagged by rsp_last). Every report value comes from one pass of a
// shared 56-step restoring divider, one result at a time; a receiver stall
// holds up the report. req_stall stays high until the last result is registered.
// One output register holds each result; while rsp_stall is high it holds
// and the sequencer waits with the next quotient ready.
// Reset (synchronous) disables counting and clears the control state and sums;
// window_frames returns to 30. Writing the enable register over csr_ clears the
// frame and window state too. No clearing pass is needed after reset.
`default_nettype none
module nested_scope_cycle_profiler #(
   parameter int BUCKETS     = 5,
   parameter int STACK_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_operation,
   input  wire  [3:0]  req_bucket,
   input  wire  [31:0] req_timestamp,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [4:0]  rsp_slot,
   output logic [25:0] rsp_value,
   output logic        rsp_last,
   input  wire         csr_write,
   input  wire  [0:0]  csr_index,
   input  wire  [7:0]  csr_data
);

   localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW  = $clog2(STACK_DEPTH + 1);
   localparam logic [4:0] SLOT_TRACKED = 5'(BUCKETS);
   localparam logic [4:0] SLOT_COST    = 5'(BUCKETS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} state_type;

   state_type state_ff, state_in;
   logic enabled_ff, enabled_in;
   logic [7:0] wf_ff, wf_in;
   logic active_ff, active_in;
   logic err_ff, err_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [3:0]  stack_bucket_ff [STACK_DEPTH];
   logic [3:0]  stack_bucket_in [STACK_DEPTH];
   logic [31:0] stack_start_ff [STACK_DEPTH];
   logic [31:0] stack_start_in [STACK_DEPTH];
   logic [31:0] frame_start_ff, frame_start_in;
   logic [31:0] frame_cyc_ff [BUCKETS];
   logic [31:0] frame_cyc_in [BUCKETS];
   logic [nscp_pkg::SUM_W-1:0] win_total_ff, win_total_in;
   logic [nscp_pkg::SUM_W-1:0] win_cyc_ff [BUCKETS];
   logic [nscp_pkg::SUM_W-1:0] win_cyc_in [BUCKETS];
   logic [7:0] count_ff, count_in;
   logic [4:0] k_ff, k_in;
   logic [nscp_pkg::TRACK_W-1:0] tracked_ff, tracked_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_slot_ff, rsp_slot_in;
   logic [25:0] rsp_value_ff, rsp_value_in;
   logic rsp_last_ff, rsp_last_in;

   nscp_pkg::div_req_type div_req;
   nscp_pkg::div_rsp_type div_rsp;

   logic [DW-1:0]  top;
   logic [SIW-1:0] tidx;
   logic [BIW-1:0] cb;
   logic [31:0]    charge;
   logic [31:0]    frame_len;
   logic [7:0]     count_next;
   logic [BIW-1:0] kidx;
   logic [nscp_pkg::TRACK_W-1:0] part;
   logic [8:0]     cnt9;
   logic [nscp_pkg::DEN_W-1:0] den;
   logic [nscp_pkg::DVD_W-1:0] q;
   logic [25:0]    share_val;
   logic           rsp_free;

   nscp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      top        = depth_ff - 1'b1;
      tidx       = top[SIW-1:0];
      cb         = stack_bucket_ff[tidx][BIW-1:0];
      charge     = req_timestamp - stack_start_ff[tidx];
      frame_len  = req_timestamp - frame_start_ff;
      count_next = count_ff + 1'b1;
      kidx       = k_ff[BIW-1:0];
      part       = (k_ff < SLOT_TRACKED) ? nscp_pkg::TRACK_W'(win_cyc_ff[kidx]) : tracked_ff;
      cnt9       = (count_ff == 8'd0) ? 9'd256 : {1'b0, count_ff};
      den        = nscp_pkg::DEN_W'(cnt9) * nscp_pkg::DEN_W'(nscp_pkg::MILLE);
      q          = div_rsp.quotient;
      if (win_total_ff == '0)
         share_val = '0;
      else if (q > nscp_pkg::DVD_W'(nscp_pkg::MILLE))
         share_val = 26'(nscp_pkg::MILLE);
      else
         share_val = q[25:0];
      rsp_free   = !rsp_valid_ff || !rsp_stall;

      div_req.start = 1'b0;
      if (k_ff == SLOT_COST) begin
         div_req.dividend = nscp_pkg::DVD_W'(win_total_ff) * nscp_pkg::DVD_W'(nscp_pkg::DECI)
                          + nscp_pkg::DVD_W'(den >> 1);
         div_req.divisor  = nscp_pkg::DVS_W'(den);
      end else begin
         div_req.dividend = nscp_pkg::DVD_W'(part) * nscp_pkg::DVD_W'(nscp_pkg::MILLE)
                          + nscp_pkg::DVD_W'(win_total_ff >> 1);
         div_req.divisor  = win_total_ff;
      end

      state_in       = state_ff;
      enabled_in     = enabled_ff;
      wf_in          = wf_ff;
      active_in      = active_ff;
      err_in         = err_ff;
      depth_in       = depth_ff;
      stack_bucket_in = stack_bucket_ff;
      stack_start_in = stack_start_ff;
      frame_start_in = frame_start_ff;
      frame_cyc_in   = frame_cyc_ff;
      win_total_in   = win_total_ff;
      win_cyc_in     = win_cyc_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      tracked_in     = tracked_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_slot_in    = rsp_slot_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && enabled_ff) begin
               case (req_operation)
                  nscp_pkg::OP_FRAME_BEGIN: begin
                     for (int i = 0; i < BUCKETS; i++) frame_cyc_in[i] = '0;
                     depth_in       = '0;
                     err_in         = 1'b0;
                     frame_start_in = req_timestamp;
                     active_in      = 1'b1;
                  end
                  nscp_pkg::OP_ENTER: begin
                     if (active_ff && !err_ff && ({1'b0, req_bucket} < 5'(BUCKETS))) begin
                        if (depth_ff != '0)
                           frame_cyc_in[cb] = frame_cyc_ff[cb] + charge;
                        if (depth_ff >= DW'(STACK_DEPTH)) begin
                           err_in = 1'b1;
                        end else begin
                           stack_bucket_in[depth_ff[SIW-1:0]] = req_bucket;
                           stack_start_in[depth_ff[SIW-1:0]]  = req_timestamp;
                           depth_in = depth_ff + 1'b1;
                        end
                     end
                  end
                  nscp_pkg::OP_LEAVE: begin
                     if (active_ff && !err_ff) begin
                        if (depth_ff == '0 || stack_bucket_ff[tidx] != req_bucket) begin
                           err_in = 1'b1;
                        end else begin
                           frame_cyc_in[cb] = frame_cyc_ff[cb] + charge;
                           depth_in = top;
                           if (top != '0)
                              stack_start_in[tidx - 1'b1] = req_timestamp;
                        end
                     end
                  end
                  default: begin
                     if (active_ff) begin
                        active_in = 1'b0;
                        if (err_ff || depth_ff != '0 || frame_len == '0) begin
                           depth_in = '0;
                           err_in   = 1'b0;
                        end else begin
                           win_total_in = win_total_ff + nscp_pkg::SUM_W'(frame_len);
                           for (int i = 0; i < BUCKETS; i++)
                              win_cyc_in[i] = win_cyc_ff[i] + nscp_pkg::SUM_W'(frame_cyc_ff[i]);
                           count_in = count_next;
                           if (!(count_next < wf_ff)) begin
                              state_in   = ST_LOAD;
                              k_in       = '0;
                              tracked_in = '0;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            div_req.start = 1'b1;
            if (k_ff < SLOT_TRACKED)
               tracked_in = tracked_ff + part;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = k_ff;
               if (k_ff == SLOT_COST) begin
                  rsp_value_in = q[25:0];
                  rsp_last_in  = 1'b1;
                  win_total_in = '0;
                  for (int i = 0; i < BUCKETS; i++) win_cyc_in[i] = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rsp_value_in = share_val;
                  rsp_last_in  = 1'b0;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         case (csr_index)
            nscp_pkg::CSR_ENABLED: begin
               enabled_in   = csr_data[0];
               state_in     = ST_IDLE;
               active_in    = 1'b0;
               err_in       = 1'b0;
               depth_in     = '0;
               frame_start_in = '0;
               for (int i = 0; i < BUCKETS; i++) begin
                  frame_cyc_in[i] = '0;
                  win_cyc_in[i]   = '0;
               end
               win_total_in = '0;
               count_in     = '0;
            end
            default: wf_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b0;
         wf_ff        <= 8'd30;
         active_ff    <= 1'b0;
         err_ff       <= 1'b0;
         depth_ff     <= '0;
         frame_start_ff <= '0;
         for (int i = 0; i < BUCKETS; i++) begin
            frame_cyc_ff[i] <= '0;
            win_cyc_ff[i]   <= '0;
         end
         win_total_ff <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         tracked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         wf_ff        <= wf_in;
         active_ff    <= active_in;
         err_ff       <= err_in;
         depth_ff     <= depth_in;
         frame_start_ff <= frame_start_in;
         frame_cyc_ff <= frame_cyc_in;
         win_cyc_ff   <= win_cyc_in;
         win_total_ff <= win_total_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         tracked_ff   <= tracked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stack_bucket_ff <= stack_bucket_in;
      stack_start_ff  <= stack_start_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire

[hw/rtl/nscp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all report results.
// Depends on nscp_pkg.
`default_nettype none
module nscp_div (
   input  wire                   clock,
   input  wire                   reset,
   input  wire nscp_pkg::div_req_type req,
   output nscp_pkg::div_rsp_type rsp
);

   logic [nscp_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [nscp_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [nscp_pkg::DVS_W-1:0]  dvs_ff;
   logic [nscp_pkg::STEP_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff;
   logic [nscp_pkg::DVS_W:0]    shifted, diff;
   logic                        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[nscp_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? diff[nscp_pkg::DVS_W-1:0] : shifted[nscp_pkg::DVS_W-1:0];
      quo_in  = {quo_ff[nscp_pkg::DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         rem_ff  <= '0;
         quo_ff  <= req.dividend;
         dvs_ff  <= req.divisor;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == nscp_pkg::STEP_W'(nscp_pkg::DVD_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire
